@@ rtl/core/msat_pkg.sv @@
// ----------------------------------------------------------------------------
// msat_pkg
// Types and constants shared by the alarm timer front end, queue and back end.
// ----------------------------------------------------------------------------
package msat_pkg;

  localparam int unsigned MS_W        = 40;
  localparam int unsigned TICKS_W     = 48;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned MS_PER_S    = 1000;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned FIRE_CNT_W  = $clog2(MAX_RESULTS + 1);
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [MS_W-1:0] MS_LIMIT = 40'd1000000000000;

  typedef enum logic [1:0] {
    OP_ARM    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_ACK    = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_ARM   = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_QUIET = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_BAD_SLOT = 2'd2
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [MS_W-1:0]   millisecond;
    logic              periodic;
    logic [SLOT_W-1:0] slot;
  } in_req_t;

  typedef struct packed {
    kind_e             kind;
    logic [SLOT_W-1:0] slot_index;
    status_e           status;
    logic              last;
  } out_rsp_t;

  // Classified command handed from the front end to the back end
  typedef struct packed {
    op_e                op;
    logic               too_long;
    logic [TICKS_W-1:0] ticks;
    logic               periodic;
    logic [SLOT_W-1:0]  slot;
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_EXEC,
    B_FINISH
  } back_state_e;

endpackage

@@ rtl/core/msat_ram.sv @@
// ----------------------------------------------------------------------------
// msat_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msat_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/msat_front.sv @@
// ----------------------------------------------------------------------------
// msat_front
// Accepts requests, checks the delay limit and converts milliseconds to
// ticks (multiply by the tick rate, then divide by 1000 with a reciprocal
// multiply built from four partial products, one a cycle).
// ----------------------------------------------------------------------------
module msat_front #(
  parameter int unsigned TICK_RATE = 1000
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  msat_pkg::in_req_t in_req_i,
  output logic              cmd_valid_o,
  output msat_pkg::cmd_t    cmd_o,
  input  logic              cmd_full_i
);
  import msat_pkg::*;

  localparam int unsigned RATE_W    = $clog2(TICK_RATE + 1);
  localparam int unsigned PROD_W    = MS_W + RATE_W;
  // 1000 = 8 * 125: drop the 8 with a shift, divide by 125 with a scaled reciprocal
  localparam int unsigned DIV_SHIFT = 3;
  localparam int unsigned DIV_ODD   = MS_PER_S >> DIV_SHIFT;
  localparam int unsigned NUM_W     = PROD_W - DIV_SHIFT;
  localparam int unsigned RECIP_SH  = NUM_W + $clog2(DIV_ODD);
  localparam int unsigned HALF_W    = (NUM_W + 2) / 2;
  localparam int unsigned ACC_W     = 4 * HALF_W;
  localparam logic [63:0] RECIP_64  =
    ((64'd1 << RECIP_SH) + 64'(DIV_ODD - 1)) / 64'(DIV_ODD);
  localparam logic [2*HALF_W-1:0] RECIP = RECIP_64[2*HALF_W-1:0];

  front_state_e        state_q, state_d;
  logic [MS_W-1:0]     ms_q, ms_d;
  logic                per_q, per_d;
  logic [2*HALF_W-1:0] num_q, num_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [1:0]          cnt_q, cnt_d;
  logic                too_long;
  logic [PROD_W-1:0]   prod;
  logic [HALF_W-1:0]   num_part, recip_part;
  logic [2*HALF_W-1:0] pp;
  logic [ACC_W-1:0]    pp_sh;

  assign prod       = PROD_W'(ms_q) * PROD_W'(TICK_RATE);
  // cnt bit 0 picks the dividend half, bit 1 the reciprocal half
  assign num_part   = cnt_q[0] ? num_q[2*HALF_W-1:HALF_W] : num_q[HALF_W-1:0];
  assign recip_part = cnt_q[1] ? RECIP[2*HALF_W-1:HALF_W] : RECIP[HALF_W-1:0];
  assign pp         = (2*HALF_W)'(num_part) * (2*HALF_W)'(recip_part);

  always_comb begin
    case (cnt_q)
      2'd0:    pp_sh = ACC_W'(pp);
      2'd3:    pp_sh = ACC_W'(pp) << (2 * HALF_W);
      default: pp_sh = ACC_W'(pp) << HALF_W;
    endcase
  end

  always_comb begin
    too_long = in_req_i.millisecond > MS_LIMIT;
    state_d  = state_q;
    ms_d     = ms_q;
    per_d    = per_q;
    num_d    = num_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;

    in_stall_o  = 1'b1;
    cmd_valid_o = 1'b0;
    cmd_o.op       = in_req_i.op;
    cmd_o.too_long = too_long;
    cmd_o.ticks    = '0;
    cmd_o.periodic = in_req_i.periodic;
    cmd_o.slot     = in_req_i.slot;

    case (state_q)
      F_IDLE: begin
        in_stall_o = cmd_full_i;
        if (in_valid_i && !cmd_full_i) begin
          if (in_req_i.op == OP_ARM && !too_long) begin
            ms_d    = in_req_i.millisecond;
            per_d   = in_req_i.periodic;
            state_d = F_MUL;
          end else begin
            cmd_valid_o = 1'b1;
          end
        end
      end
      F_MUL: begin
        num_d   = (2*HALF_W)'(prod >> DIV_SHIFT);
        acc_d   = '0;
        cnt_d   = '0;
        state_d = F_DIV;
      end
      F_DIV: begin
        acc_d = acc_q + pp_sh;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 2'd3) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        cmd_valid_o    = 1'b1;
        cmd_o.op       = OP_ARM;
        cmd_o.too_long = 1'b0;
        cmd_o.ticks    = TICKS_W'(acc_q >> RECIP_SH);
        cmd_o.periodic = per_q;
        cmd_o.slot     = '0;
        if (!cmd_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ms_q  <= ms_d;
    per_q <= per_d;
    num_q <= num_d;
    acc_q <= acc_d;
    cnt_q <= cnt_d;
  end

endmodule

@@ rtl/core/msat_queue.sv @@
// ----------------------------------------------------------------------------
// msat_queue
// Short command FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module msat_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  msat_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  output logic           pop_valid_o,
  output msat_pkg::cmd_t pop_cmd_o,
  input  logic           pop_i
);
  import msat_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign full_o      = cnt_q == CNT_W'(QUEUE_DEPTH);
  assign pop_valid_o = cnt_q != '0;
  assign pop_cmd_o   = mem_q[rd_ptr_q];
  assign push        = push_valid_i && !full_o;
  assign pop         = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ rtl/core/msat_back.sv @@
// ----------------------------------------------------------------------------
// msat_back
// Executes commands against the slot bank: arm, cancel, acknowledge and the
// tick walk over all slots, with the result register on the output side.
// ----------------------------------------------------------------------------
module msat_back #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  msat_pkg::cmd_t     cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  output msat_pkg::out_rsp_t out_rsp_o,
  input  logic               out_stall_i
);
  import msat_pkg::*;

  localparam int unsigned SW     = $clog2(NUM_SLOTS);
  localparam int unsigned WORD_W = 2 * TICKS_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);

  back_state_e           state_q, state_d;
  logic [SW-1:0]         idx_q, idx_d;
  logic [NUM_SLOTS-1:0]  used_q, used_d;
  logic [NUM_SLOTS-1:0]  listed_q, listed_d;
  logic [NUM_SLOTS-1:0]  await_q, await_d;
  logic [NUM_SLOTS-1:0]  period_q, period_d;   // reload period is nonzero
  logic [FIRE_CNT_W-1:0] fire_cnt_q, fire_cnt_d;
  logic                  held_v_q, held_v_d;
  logic [SW-1:0]         held_idx_q, held_idx_d;
  logic                  out_valid_q, out_valid_d;
  out_rsp_t              out_q, out_d;

  logic                  ram_we, ram_re;
  logic [SW-1:0]         ram_waddr, ram_raddr;
  logic [WORD_W-1:0]     ram_wdata, ram_rdata;
  logic [TICKS_W-1:0]    rd_count, rd_reload;

  logic                  out_free;
  logic                  push_out;
  out_rsp_t              push_rsp;
  logic                  any_free;
  logic [SW-1:0]         free_idx;
  logic                  s_ok;
  logic [SW-1:0]         s_idx;
  logic                  fire, emit, blocked;

  msat_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_count  = ram_rdata[TICKS_W-1:0];
  assign rd_reload = ram_rdata[WORD_W-1:TICKS_W];
  assign out_free  = !out_valid_q || !out_stall_i;
  assign s_idx     = SW'(cmd_i.slot);
  assign s_ok      = (32'(cmd_i.slot) < NUM_SLOTS) && used_q[s_idx];

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = SW'(i);
      end
    end
    any_free = ~&used_q;
  end

  assign fire    = (rd_count == '0) && !await_q[idx_q];
  assign emit    = fire && (fire_cnt_q < FIRE_CNT_W'(MAX_RESULTS));
  assign blocked = emit && held_v_q && !out_free;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    used_d     = used_q;
    listed_d   = listed_q;
    await_d    = await_q;
    period_d   = period_q;
    fire_cnt_d = fire_cnt_q;
    held_v_d   = held_v_q;
    held_idx_d = held_idx_q;

    cmd_pop_o = 1'b0;
    push_out  = 1'b0;
    push_rsp  = '{kind: KIND_ARM, slot_index: '0, status: ST_OK, last: 1'b1};
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = {rd_reload, rd_count - 1'b1};
    ram_re    = 1'b0;
    ram_raddr = idx_q;

    case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_TICK: begin
              cmd_pop_o  = 1'b1;
              idx_d      = '0;
              fire_cnt_d = '0;
              held_v_d   = 1'b0;
              state_d    = B_READ;
            end
            OP_ARM: begin
              if (out_free) begin
                cmd_pop_o = 1'b1;
                push_out  = 1'b1;
                if (cmd_i.too_long) begin
                  push_rsp.status = ST_TOO_LONG;
                end else if (!any_free) begin
                  push_rsp.status = ST_BAD_SLOT;
                end else begin
                  used_d[free_idx]   = 1'b1;
                  listed_d[free_idx] = 1'b1;
                  await_d[free_idx]  = 1'b0;
                  period_d[free_idx] = cmd_i.periodic && (cmd_i.ticks != '0);
                  ram_we    = 1'b1;
                  ram_waddr = free_idx;
                  ram_wdata = {(cmd_i.periodic ? cmd_i.ticks : '0), cmd_i.ticks};
                  push_rsp.slot_index = SLOT_W'(free_idx);
                end
              end
            end
            OP_CANCEL, OP_ACK: begin
              if (out_free) begin
                cmd_pop_o           = 1'b1;
                push_out            = 1'b1;
                push_rsp.kind       = KIND_DONE;
                push_rsp.slot_index = cmd_i.slot;
                if (!s_ok) begin
                  push_rsp.status = ST_BAD_SLOT;
                end else begin
                  await_d[s_idx] = 1'b0;
                  // ack of a periodic slot only clears its pending mark
                  if (cmd_i.op == OP_CANCEL || !period_q[s_idx]) begin
                    used_d[s_idx]   = 1'b0;
                    listed_d[s_idx] = 1'b0;
                  end
                end
              end
            end
            default: begin
              state_d = B_IDLE;
            end
          endcase
        end
      end
      B_READ: begin
        if (listed_q[idx_q]) begin
          ram_re  = 1'b1;
          state_d = B_EXEC;
        end else if (idx_q == LAST_SLOT) begin
          state_d = B_FINISH;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      B_EXEC: begin
        // fired results trail by one so the final one can carry last
        if (!blocked) begin
          if (rd_count != '0) begin
            ram_we = 1'b1;
          end else begin
            listed_d[idx_q] = period_q[idx_q];
            if (!await_q[idx_q]) begin
              await_d[idx_q] = 1'b1;
              ram_we    = 1'b1;
              ram_wdata = {rd_reload, rd_reload};
            end
            if (emit) begin
              fire_cnt_d = fire_cnt_q + 1'b1;
              if (held_v_q) begin
                push_out = 1'b1;
                push_rsp = '{kind: KIND_FIRED, slot_index: SLOT_W'(held_idx_q),
                             status: ST_OK, last: 1'b0};
              end
              held_v_d   = 1'b1;
              held_idx_d = idx_q;
            end
          end
          if (idx_q == LAST_SLOT) begin
            state_d = B_FINISH;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = B_READ;
          end
        end
      end
      B_FINISH: begin
        if (out_free) begin
          push_out = 1'b1;
          if (held_v_q) begin
            push_rsp = '{kind: KIND_FIRED, slot_index: SLOT_W'(held_idx_q),
                         status: ST_OK, last: 1'b1};
          end else begin
            push_rsp = '{kind: KIND_QUIET, slot_index: '0, status: ST_OK, last: 1'b1};
          end
          held_v_d = 1'b0;
          state_d  = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (push_out) begin
      out_valid_d = 1'b1;
      out_d       = push_rsp;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      idx_q       <= '0;
      used_q      <= '0;
      listed_q    <= '0;
      await_q     <= '0;
      period_q    <= '0;
      fire_cnt_q  <= '0;
      held_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      used_q      <= used_d;
      listed_q    <= listed_d;
      await_q     <= await_d;
      period_q    <= period_d;
      fire_cnt_q  <= fire_cnt_d;
      held_v_q    <= held_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_idx_q <= held_idx_d;
    out_q      <= out_d;
  end

`ifndef SYNTHESIS
  a_listed_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (listed_q & ~used_q) == '0)
    else $error("listed slot not in use");

  a_await_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (await_q & ~used_q) == '0)
    else $error("pending mark on a free slot");

  a_fire_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_cnt_q <= FIRE_CNT_W'(MAX_RESULTS))
    else $error("fired result count over limit");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> cmd_valid_i)
    else $error("queue popped while empty");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_out |-> out_free)
    else $error("result register overwritten while stalled");
`endif

endmodule

@@ rtl/core/multi_slot_alarm_timer_core.sv @@
// ----------------------------------------------------------------------------
// multi_slot_alarm_timer_core
// Bank of one-shot and periodic alarm slots with arm, cancel, acknowledge
// and tick requests; fired slots are reported in slot order.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in      | input     | in_valid_i / in_stall_o | in_req_i  (op, ms, per, slot)
//  out     | output    | out_valid_o/out_stall_i | out_rsp_o (kind, slot, status, last)
//
//  Arm: front end steps through accept, tick-rate multiply, four partial
//    products of the divide by 1000 and push; a too-long delay skips the math.
//  Cancel, acknowledge, arm reply: done in the back-end idle state once the output is free.
//  Tick: back end walks all slots through the slot RAM read port, reading only
//    listed slots (B_READ, then B_EXEC), then B_FINISH; fires follow one per slot.
//  Reset clears all slot flags at once; no clearing pass. Either side may stall
//    independently through the two-entry command queue.
// ----------------------------------------------------------------------------
module multi_slot_alarm_timer_core #(
  parameter int unsigned NUM_SLOTS = 16,
  parameter int unsigned TICK_RATE = 1000
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  msat_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output msat_pkg::out_rsp_t out_rsp_o
);
  import msat_pkg::*;

  logic cmd_push_valid, cmd_full;
  cmd_t cmd_push;
  logic cmd_valid, cmd_pop;
  cmd_t cmd_head;

  msat_front #(
    .TICK_RATE (TICK_RATE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .cmd_valid_o (cmd_push_valid),
    .cmd_o       (cmd_push),
    .cmd_full_i  (cmd_full)
  );

  msat_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_push_valid),
    .push_cmd_i   (cmd_push),
    .full_o       (cmd_full),
    .pop_valid_o  (cmd_valid),
    .pop_cmd_o    (cmd_head),
    .pop_i        (cmd_pop)
  );

  msat_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .out_stall_i (out_stall_i)
  );

endmodule

@@ tb/multi_slot_alarm_timer_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_alarm_timer_core_tb
// Drives arm, cancel, acknowledge and tick requests into the alarm timer with
// random gaps on both channels, tracks the slot bank alongside the block and
// checks every response, in order, against the tracked bank.
// ----------------------------------------------------------------------------
module multi_slot_alarm_timer_core_tb;
  import msat_pkg::*;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned TICKS_PER_S  = 1000;
  localparam int unsigned FIRE_LIMIT   = 16;
  localparam logic [63:0] DELAY_MAX_MS = 64'd1000000000000;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE_CYC   = 64;

  typedef struct {
    in_req_t req;
    bit      drain;  // hold off until all responses are in
  } stim_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_rsp_t out_rsp_o;

  stim_t    stim_q[$];
  out_rsp_t pending_rsp_q[$];
  logic     in_taken = 1'b0;
  int       cycle_cnt = 0;
  int       fail_cnt = 0;
  logic     calm;

  // tracked slot bank
  logic        bank_used   [SLOTS];
  logic        bank_listed [SLOTS];
  logic        bank_pend   [SLOTS];
  logic [47:0] bank_cnt    [SLOTS];
  logic [47:0] bank_period [SLOTS];

  multi_slot_alarm_timer_core #(
    .NUM_SLOTS(SLOTS),
    .TICK_RATE(TICKS_PER_S)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  always #4 clk_i = ~clk_i;

  // no random idling in this window
  assign calm = (cycle_cnt >= 3000) && (cycle_cnt < 6000);

  function automatic void push_rsp(kind_e k, logic [3:0] idx, status_e st);
    out_rsp_t r;
    r.kind       = k;
    r.slot_index = idx;
    r.status     = st;
    r.last       = 1'b0;
    pending_rsp_q.push_back(r);
  endfunction

  function automatic void timer_step(in_req_t r);
    int          fired;
    int          found;
    logic [63:0] prod;
    logic [47:0] ticks;
    out_rsp_t    tail;
    fired = 0;
    found = -1;
    case (r.op)
      OP_ARM: begin
        if (64'(r.millisecond) > DELAY_MAX_MS) begin
          push_rsp(KIND_ARM, 4'd0, ST_TOO_LONG);
        end else begin
          prod  = 64'(r.millisecond) * 64'(TICKS_PER_S) / 64'(1000);
          ticks = prod[47:0];
          for (int i = 0; i < SLOTS; i++) begin
            if (!bank_used[i] && found < 0) found = i;
          end
          if (found < 0) begin
            push_rsp(KIND_ARM, 4'd0, ST_BAD_SLOT);
          end else begin
            bank_used[found]   = 1'b1;
            bank_listed[found] = 1'b1;
            bank_pend[found]   = 1'b0;
            bank_cnt[found]    = ticks;
            bank_period[found] = r.periodic ? ticks : 48'd0;
            push_rsp(KIND_ARM, 4'(found), ST_OK);
          end
        end
      end
      OP_CANCEL, OP_ACK: begin
        if (r.slot >= SLOTS || !bank_used[r.slot]) begin
          push_rsp(KIND_DONE, r.slot, ST_BAD_SLOT);
        end else begin
          if (r.op == OP_CANCEL || bank_period[r.slot] == 48'd0) begin
            bank_used[r.slot]   = 1'b0;
            bank_listed[r.slot] = 1'b0;
          end
          bank_pend[r.slot] = 1'b0;
          push_rsp(KIND_DONE, r.slot, ST_OK);
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (bank_listed[i]) begin
            if (bank_cnt[i] != 48'd0) begin
              bank_cnt[i] = bank_cnt[i] - 48'd1;
            end else begin
              bank_listed[i] = 1'b0;
              if (!bank_pend[i]) begin
                bank_pend[i] = 1'b1;
                bank_cnt[i]  = bank_period[i];
                if (fired < FIRE_LIMIT) push_rsp(KIND_FIRED, 4'(i), ST_OK);
                fired++;
              end
              if (bank_period[i] != 48'd0) bank_listed[i] = 1'b1;
            end
          end
        end
        if (fired == 0) push_rsp(KIND_QUIET, 4'd0, ST_OK);
      end
    endcase
    tail = pending_rsp_q.pop_back();
    tail.last = 1'b1;
    pending_rsp_q.push_back(tail);
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  // sampling, prediction and checking at the rising edge
  always @(posedge clk_i) begin : monitor
    out_rsp_t exp_rsp;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_rsp_q.size() == 0) begin
          $display("%0t: unexpected response: expected none, actual kind=%0d slot=%0d status=%0d last=%0d",
                   $time, out_rsp_o.kind, out_rsp_o.slot_index, out_rsp_o.status,
                   out_rsp_o.last);
          fail_cnt++;
        end else begin
          exp_rsp = pending_rsp_q.pop_front();
          check_field("kind", int'(exp_rsp.kind), int'(out_rsp_o.kind));
          check_field("slot_index", int'(exp_rsp.slot_index), int'(out_rsp_o.slot_index));
          check_field("status", int'(exp_rsp.status), int'(out_rsp_o.status));
          check_field("last", int'(exp_rsp.last), int'(out_rsp_o.last));
        end
      end
      if (in_valid_i && !in_stall_o) timer_step(in_req_i);
      in_taken <= in_valid_i && !in_stall_o;
    end
  end

  // request driver and response stall at the falling edge
  always @(negedge clk_i) begin : driver
    stim_t nxt;
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (stim_q.size() != 0 && !(stim_q[0].drain && pending_rsp_q.size() != 0) &&
            (calm || $urandom_range(99) >= 18)) begin
          nxt = stim_q.pop_front();
          in_req_i   <= nxt.req;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !calm && ($urandom_range(99) < 18);
    end
  end

  function automatic logic [39:0] any_ms();
    return {8'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [39:0] pick_delay();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) return 40'($urandom_range(4));
    if (r < 85) return 40'($urandom_range(40, 5));
    if (r < 90) return 40'(DELAY_MAX_MS - 64'($urandom_range(2))) + 40'($urandom_range(3));
    return any_ms();
  endfunction

  function automatic logic [3:0] pick_slot();
    return ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(7));
  endfunction

  task automatic add_req(op_e op, logic [39:0] ms, logic per, logic [3:0] slot,
                         bit drain = 1'b0);
    stim_t s;
    s.req.op          = op;
    s.req.millisecond = ms;
    s.req.periodic    = per;
    s.req.slot        = slot;
    s.drain           = drain;
    stim_q.push_back(s);
  endtask

  initial begin : stimulus
    int unsigned pick;
    int unsigned cnt;
    for (int i = 0; i < SLOTS; i++) begin
      bank_used[i]   = 1'b0;
      bank_listed[i] = 1'b0;
      bank_pend[i]   = 1'b0;
      bank_cnt[i]    = '0;
      bank_period[i] = '0;
    end

    // directed: rejects, zero-tick alarms, early acks, held fires
    add_req(OP_TICK, any_ms(), 1'b1, 4'd9);
    add_req(OP_CANCEL, any_ms(), 1'b0, 4'd5);
    add_req(OP_ACK, any_ms(), 1'b1, 4'd15);
    add_req(OP_ARM, '1, 1'b0, 4'd0);
    add_req(OP_ARM, 40'(DELAY_MAX_MS + 64'd1), 1'b1, 4'd0);
    add_req(OP_ARM, 40'(DELAY_MAX_MS), 1'b1, 4'd0);
    add_req(OP_ARM, 40'd0, 1'b0, 4'd0);
    add_req(OP_ARM, 40'd0, 1'b1, 4'd0);
    add_req(OP_ARM, 40'd1, 1'b1, 4'd0);
    add_req(OP_ARM, 40'd2, 1'b0, 4'd0);
    add_req(OP_ACK, any_ms(), 1'b0, 4'd4);
    add_req(OP_ACK, any_ms(), 1'b0, 4'd3);
    add_req(OP_TICK, any_ms(), 1'b0, 4'd0);
    add_req(OP_TICK, any_ms(), 1'b0, 4'd0);
    add_req(OP_TICK, any_ms(), 1'b0, 4'd0);
    add_req(OP_TICK, any_ms(), 1'b0, 4'd0);
    add_req(OP_ACK, any_ms(), 1'b0, 4'd3);
    add_req(OP_TICK, any_ms(), 1'b0, 4'd0);
    add_req(OP_ACK, any_ms(), 1'b0, 4'd1);
    add_req(OP_CANCEL, any_ms(), 1'b0, 4'd2);
    add_req(OP_CANCEL, any_ms(), 1'b0, 4'd3);
    add_req(OP_CANCEL, any_ms(), 1'b0, 4'd0, 1'b1);
    add_req(OP_CANCEL, any_ms(), 1'b0, 4'd0);

    // full bank: one arm too many, then every slot fires on one tick
    for (int i = 0; i <= SLOTS; i++) add_req(OP_ARM, 40'd0, 1'($urandom), 4'($urandom));
    add_req(OP_TICK, any_ms(), 1'b0, 4'd0);
    add_req(OP_TICK, any_ms(), 1'b0, 4'd0);
    for (int i = 0; i < SLOTS; i++) add_req(OP_CANCEL, any_ms(), 1'b0, 4'(i));

    while (stim_q.size() < 480) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        cnt = $urandom_range(4, 1);
        for (int i = 0; i < cnt; i++) begin
          add_req(OP_ARM, pick_delay(), 1'($urandom), 4'($urandom),
                  i == 0 && $urandom_range(19) == 0);
        end
        cnt = $urandom_range(8, 2);
        for (int i = 0; i < cnt; i++) begin
          case ($urandom_range(5))
            0:       add_req(OP_ACK, any_ms(), 1'($urandom), pick_slot());
            1:       add_req(OP_CANCEL, any_ms(), 1'($urandom), pick_slot());
            default: add_req(OP_TICK, any_ms(), 1'($urandom), 4'($urandom));
          endcase
        end
      end else if (pick < 63) begin
        for (int i = 0; i <= SLOTS; i++) begin
          add_req(OP_ARM, 40'($urandom_range(2)), 1'($urandom), 4'($urandom));
        end
        for (int i = 0; i < 3; i++) add_req(OP_TICK, any_ms(), 1'($urandom), 4'($urandom));
        for (int i = 0; i < SLOTS; i++) begin
          add_req($urandom_range(1) ? OP_CANCEL : OP_ACK, any_ms(), 1'($urandom), 4'(i));
        end
      end else if (pick < 75) begin
        for (int i = 0; i < SLOTS; i++) begin
          add_req($urandom_range(2) != 0 ? OP_CANCEL : OP_ACK, any_ms(), 1'($urandom), 4'(i));
        end
      end else begin
        cnt = $urandom_range(4, 1);
        for (int i = 0; i < cnt; i++) begin
          add_req(op_e'($urandom_range(3)), any_ms(), 1'($urandom), 4'($urandom));
        end
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || in_valid_i || pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
